// ----- rtl/core/okpt_pkg.sv -----
// Shared types, codes and sizing for the ordered keyed point table.
package okpt_pkg;

    localparam int DEF_MAX_POINTS = 16;
    localparam int VCOUNT_W       = 17;
    localparam int KEY_W          = 16;
    localparam int POS_W          = 32;
    localparam int OUT_CNT_W      = 5;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_UPSERT   = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_LOOKUP   = 3'd3;
    localparam logic [2:0] CMD_READ_ALL = 3'd4;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_PRESENT  = 3'd6,
        ST_ENTRY    = 3'd7
    } t_status;

    // where the reported entry comes from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_ITEM = 2'd2
    } t_src;

    // what the entry memory write port stores, and where
    typedef enum logic [1:0] {
        WR_ITEM_FILL = 2'd0,
        WR_ITEM_IDX  = 2'd1,
        WR_SHIFT     = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic [2:0]              command;
        logic [KEY_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic                    hit;
        logic [KEY_W-1:0]        entry_vertex;
        logic signed [POS_W-1:0] entry_x;
        logic signed [POS_W-1:0] entry_y;
        logic signed [POS_W-1:0] entry_z;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_next;
        logic    idx_inc;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    emit;
        t_status status;
        logic    hit;
        t_src    src;
        logic    last;
        logic    fill_inc;
        logic    fill_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic       in_range;
        logic       fill_zero;
        logic       full;
        logic       key_match;
        logic       scan_last;
        logic       ra_last;
        logic       shift_more;
        logic       out_busy;
    } t_dp_sts;

endpackage

// ----- rtl/core/ordered_keyed_point_table_top.sv -----
// Ordered keyed point table: an insertion-ordered table of up to MAX_POINTS
// vertex-keyed Q16.16 positions with add, upsert, remove, lookup and read-all
// commands. One item is worked on at a time; the input stalls until the item's
// last result has been loaded into the output register and, for a remove, the
// entries behind the removed one have moved down. The entry memory has one
// read port; each entry visited is first read, then compared, moved or reported.
// The vertex_count register resets to 0, so every key is out of range until it
// is written. The configuration port is always ready.
module ordered_keyed_point_table_top import okpt_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [VCOUNT_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    okpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    okpt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // a result that is not the last one means the item is still being worked on
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> o_in_stall)
        else $error("input open while results of an item are still pending");

    // an entry report without a hit only occurs for read all of an empty table
    a_empty_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_ENTRY && !o_out_item.hit)
            |-> (o_out_item.entry_count == '0 && o_out_item.last))
        else $error("entry result without hit on a non-empty table");
`endif

endmodule

// ----- rtl/core/okpt_dp.sv -----
// Datapath: item register, entry memory, fill count, range register and result register.
module okpt_dp import okpt_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int SW = CW + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  t_in_item            i_in_item,
    input  logic                i_cfg_valid,
    input  logic [VCOUNT_W-1:0] i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    t_entry              mem [MAX_POINTS];
    t_entry              r_rd;
    t_in_item            r_item;
    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       n_fill;
    logic [VCOUNT_W-1:0] r_vcount;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        item_entry;
    logic [SW-1:0] idx_p1;

    assign item_entry = '{key: r_item.vertex_index, x: r_item.pos_x,
                          y: r_item.pos_y, z: r_item.pos_z};
    assign idx_p1     = SW'(r_idx) + SW'(1);

    always_comb begin
        rd_addr = i_cmd.rd_next ? (r_idx + IW'(1)) : r_idx;
        case (i_cmd.wr_sel)
            WR_ITEM_FILL: begin
                wr_addr = IW'(r_fill);
                wr_data = item_entry;
            end
            WR_ITEM_IDX: begin
                wr_addr = r_idx;
                wr_data = item_entry;
            end
            WR_SHIFT: begin
                wr_addr = r_idx;
                wr_data = r_rd;
            end
            default: begin
                wr_addr = r_idx;
                wr_data = r_rd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.status      = i_cmd.status;
        n_out.hit         = i_cmd.hit;
        n_out.last        = i_cmd.last;
        n_out.entry_count = OUT_CNT_W'(n_fill);
        case (i_cmd.src)
            SRC_MEM: begin
                n_out.entry_vertex = r_rd.key;
                n_out.entry_x      = r_rd.x;
                n_out.entry_y      = r_rd.y;
                n_out.entry_z      = r_rd.z;
            end
            SRC_ITEM: begin
                n_out.entry_vertex = r_item.vertex_index;
                n_out.entry_x      = r_item.pos_x;
                n_out.entry_y      = r_item.pos_y;
                n_out.entry_z      = r_item.pos_z;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_idx  <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.command    = r_item.command;
    assign o_sts.in_range   = {1'b0, r_item.vertex_index} < r_vcount;
    assign o_sts.fill_zero  = (r_fill == '0);
    assign o_sts.full       = (r_fill == CW'(MAX_POINTS));
    assign o_sts.key_match  = (r_rd.key == r_item.vertex_index);
    assign o_sts.scan_last  = (idx_p1 >= SW'(r_fill));
    assign o_sts.ra_last    = (idx_p1 == SW'(r_fill));
    // after the remove has decremented the count, entry idx+1 exists while idx < count
    assign o_sts.shift_more = (SW'(r_idx) < SW'(r_fill));
    assign o_sts.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/core/okpt_ctrl.sv -----
// Controller: sequences key scan, insert, update, remove shift and readout.
module okpt_ctrl import okpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESOLVE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RA_RD,
        S_RA_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_found;
    logic   n_found;
    logic   bad_cmd;

    assign bad_cmd    = (i_sts.command > CMD_READ_ALL);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_found = r_found;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.command == CMD_READ_ALL) begin
                    if (!i_sts.fill_zero) begin
                        n_state = S_RA_RD;
                    end else if (!i_sts.out_busy) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_ENTRY;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (bad_cmd || (i_sts.command != CMD_LOOKUP && !i_sts.in_range)) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_RANGE;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.fill_zero) begin
                    n_found = 1'b0;
                    n_state = S_RESOLVE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.key_match) begin
                    n_found = 1'b1;
                    n_state = S_RESOLVE;
                end else if (i_sts.scan_last) begin
                    n_found = 1'b0;
                    n_state = S_RESOLVE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_RESOLVE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                    if (i_sts.command == CMD_LOOKUP) begin
                        o_cmd.status = r_found ? ST_ENTRY : ST_NOTFOUND;
                        o_cmd.hit    = r_found;
                        o_cmd.src    = r_found ? SRC_MEM : SRC_NONE;
                    end else if (i_sts.command == CMD_REMOVE) begin
                        if (r_found) begin
                            o_cmd.status   = ST_REMOVED;
                            o_cmd.hit      = 1'b1;
                            o_cmd.src      = SRC_MEM;
                            o_cmd.fill_dec = 1'b1;
                            n_state        = S_SHIFT_RD;
                        end else begin
                            o_cmd.status = ST_NOTFOUND;
                        end
                    end else if (r_found) begin
                        o_cmd.hit = 1'b1;
                        if (i_sts.command == CMD_ADD) begin
                            o_cmd.status = ST_PRESENT;
                            o_cmd.src    = SRC_MEM;
                        end else begin
                            o_cmd.status = ST_UPDATED;
                            o_cmd.src    = SRC_ITEM;
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_ITEM_IDX;
                        end
                    end else if (i_sts.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.status   = ST_INSERTED;
                        o_cmd.src      = SRC_ITEM;
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.wr_sel   = WR_ITEM_FILL;
                        o_cmd.fill_inc = 1'b1;
                    end
                end
            end
            // close the gap: move entry idx+1 down to idx until the end
            S_SHIFT_RD: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_SHIFT;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_SHIFT_RD;
            end
            S_RA_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RA_EMIT;
            end
            S_RA_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_ENTRY;
                    o_cmd.hit    = 1'b1;
                    o_cmd.src    = SRC_MEM;
                    o_cmd.last   = i_sts.ra_last;
                    if (i_sts.ra_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RA_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

endmodule

// ----- verif/tb_ordered_keyed_point_table_top.sv -----
// Self-checking testbench for the ordered keyed point table, with its own table predictor.
module tb_ordered_keyed_point_table_top;
    import okpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = DEF_MAX_POINTS;
    localparam int POOL_N    = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_data = '0;

    ordered_keyed_point_table_top #(
        .MAX_POINTS(TBL_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted table contents
    t_entry              pts [TBL_DEPTH];
    int                  pts_n = 0;
    logic [VCOUNT_W-1:0] vcount_m = '0;

    t_in_item   cmd_q[$];
    t_out_item  result_q[$];
    logic [KEY_W-1:0] key_pool [POOL_N];

    int   fails = 0;
    bit   steady = 1'b0;
    int   hold_req = 0;
    int   hold_left = 0;
    logic in_took;

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < pts_n; i++) begin
            if (pts[i].key == k) return i;
        end
        return -1;
    endfunction

    task automatic push_result(t_status st, logic hit, t_entry e, logic last);
        t_out_item r;
        r.status       = st;
        r.hit          = hit;
        r.entry_vertex = e.key;
        r.entry_x      = e.x;
        r.entry_y      = e.y;
        r.entry_z      = e.z;
        r.entry_count  = pts_n[OUT_CNT_W-1:0];
        r.last         = last;
        result_q.insert(result_q.size(), r);
    endtask

    task automatic predict_table(t_in_item it);
        int     slot;
        t_entry e;
        t_entry none;
        none  = '0;
        e.key = it.vertex_index;
        e.x   = it.pos_x;
        e.y   = it.pos_y;
        e.z   = it.pos_z;
        slot  = find_key(it.vertex_index);
        if (it.command == CMD_READ_ALL) begin
            if (pts_n == 0) begin
                push_result(ST_ENTRY, 1'b0, none, 1'b1);
            end else begin
                for (int i = 0; i < pts_n; i++)
                    push_result(ST_ENTRY, 1'b1, pts[i], i == pts_n - 1);
            end
        end else if (it.command == CMD_LOOKUP) begin
            // lookup skips the range check
            if (slot >= 0) push_result(ST_ENTRY, 1'b1, pts[slot], 1'b1);
            else push_result(ST_NOTFOUND, 1'b0, none, 1'b1);
        end else if (it.command > CMD_READ_ALL || it.vertex_index >= vcount_m) begin
            push_result(ST_RANGE, 1'b0, none, 1'b1);
        end else if (it.command == CMD_REMOVE) begin
            if (slot < 0) begin
                push_result(ST_NOTFOUND, 1'b0, none, 1'b1);
            end else begin
                e = pts[slot];
                for (int i = slot; i < pts_n - 1; i++) pts[i] = pts[i+1];
                pts_n--;
                push_result(ST_REMOVED, 1'b1, e, 1'b1);
            end
        end else if (slot >= 0) begin
            if (it.command == CMD_ADD) begin
                push_result(ST_PRESENT, 1'b1, pts[slot], 1'b1);
            end else begin
                pts[slot].x = it.pos_x;
                pts[slot].y = it.pos_y;
                pts[slot].z = it.pos_z;
                push_result(ST_UPDATED, 1'b1, pts[slot], 1'b1);
            end
        end else if (pts_n >= TBL_DEPTH) begin
            push_result(ST_FULL, 1'b0, none, 1'b1);
        end else begin
            pts[pts_n] = e;
            pts_n++;
            push_result(ST_INSERTED, 1'b0, e, 1'b1);
        end
    endtask

    // driver: acceptance seen at the rising edge, next item offered at the falling edge
    always @(posedge clk) begin
        in_took = rst_n && in_valid && !in_stall;
        @(negedge clk);
        if (in_took) predict_table(in_item);
        if (!in_valid || in_took) begin
            if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
                in_item  <= cmd_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(99) < 9);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fails++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // monitor
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                fails++;
                $error("result with nothing pending: status %0d vertex %0h",
                       out_item.status, out_item.entry_vertex);
            end else begin
                want = result_q.pop_front();
                check_field("status", want.status, out_item.status);
                check_field("hit", want.hit, out_item.hit);
                check_field("entry_vertex", want.entry_vertex, out_item.entry_vertex);
                check_field("entry_x", want.entry_x, out_item.entry_x);
                check_field("entry_y", want.entry_y, out_item.entry_y);
                check_field("entry_z", want.entry_z, out_item.entry_z);
                check_field("entry_count", want.entry_count, out_item.entry_count);
                check_field("last", want.last, out_item.last);
            end
        end
    end

    function automatic t_in_item make_cmd(logic [2:0] c, logic [KEY_W-1:0] k,
                                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in_item it;
        it.command      = c;
        it.vertex_index = k;
        it.pos_x        = x;
        it.pos_y        = y;
        it.pos_z        = z;
        return it;
    endfunction

    task automatic send(logic [2:0] c, logic [KEY_W-1:0] k,
                        logic [31:0] x = $urandom, logic [31:0] y = $urandom,
                        logic [31:0] z = $urandom);
        cmd_q.insert(cmd_q.size(), make_cmd(c, k, x, y, z));
    endtask

    task automatic drain();
        do @(posedge clk); while (cmd_q.size() != 0 || in_valid || result_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(logic [VCOUNT_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        vcount_m = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // keys mostly in range; below 65536 the last three are at or above the vertex count, all are when it is 0
    task automatic pick_pool(int vc);
        for (int i = 0; i < POOL_N; i++) begin
            if (vc == 0 || (vc < 65536 && i >= POOL_N - 3))
                key_pool[i] = KEY_W'($urandom_range(65535, vc));
            else
                key_pool[i] = KEY_W'($urandom_range(vc - 1, 0));
        end
    endtask

    task automatic queue_random(int count);
        int r;
        logic [2:0] c;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 32) c = CMD_ADD;
            else if (r < 47) c = CMD_UPSERT;
            else if (r < 65) c = CMD_REMOVE;
            else if (r < 80) c = CMD_LOOKUP;
            else if (r < 92) c = CMD_READ_ALL;
            else c = 3'($urandom_range(7, 5));
            if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_N - 1)];
            else k = KEY_W'($urandom);
            send(c, k);
        end
    endtask

    // remove everything currently held, so a smaller vertex count starts clean
    task automatic empty_table();
        for (int i = 0; i < pts_n; i++) send(CMD_REMOVE, pts[i].key);
        drain();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // vertex count still zero: every keyed write is refused
        send(CMD_ADD, 16'd0);
        send(CMD_UPSERT, 16'd5);
        send(CMD_REMOVE, 16'hFFFF);
        send(CMD_LOOKUP, 16'd5);
        send(CMD_READ_ALL, 16'd0);
        send(3'd5, 16'd9);
        send(3'd6, 16'hFFFF);
        drain();

        write_count(17'd65536);
        send(CMD_ADD, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_ADD, 16'hFFFF, 32'h0, 32'h0001_0000, 32'h8000_0000);
        send(CMD_ADD, 16'd0, 32'h1234_5678, 32'h0, 32'h0);
        send(CMD_UPSERT, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send(CMD_UPSERT, 16'd1234);
        send(CMD_LOOKUP, 16'd0);
        send(CMD_LOOKUP, 16'd7);
        send(CMD_READ_ALL, 16'd0);
        send(CMD_REMOVE, 16'd0);
        send(CMD_REMOVE, 16'd0);
        send(CMD_READ_ALL, 16'hFFFF);
        send(3'd7, 16'd0);
        drain();

        // fill past capacity, then churn
        pick_pool(65536);
        for (int i = 0; i < POOL_N; i++) send(CMD_ADD, key_pool[i]);
        send(CMD_READ_ALL, 16'd0);
        queue_random(10);
        drain();

        // output held off for a long stretch while items keep coming
        hold_req = 150;
        queue_random(25);
        drain();
        empty_table();

        write_count(17'd300);
        pick_pool(300);
        steady = 1'b1;
        for (int i = 0; i < 18; i++) send(CMD_ADD, key_pool[i]);
        queue_random(10);
        drain();
        steady = 1'b0;
        empty_table();

        write_count(17'd1);
        pick_pool(1);
        queue_random(15);
        drain();
        empty_table();

        write_count(VCOUNT_W'($urandom_range(65535, 2)));
        pick_pool(int'(vcount_m));
        queue_random(10);
        drain();

        repeat (20) @(posedge clk);
        if (fails == 0) begin
            $display("tb_ordered_keyed_point_table_top passed");
        end else begin
            $display("tb_ordered_keyed_point_table_top failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_ordered_keyed_point_table_top failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/okpt_pkg.sv
rtl/core/okpt_dp.sv
rtl/core/okpt_ctrl.sv
rtl/core/ordered_keyed_point_table_top.sv
verif/tb_ordered_keyed_point_table_top.sv
